@@ rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_FRAMES     = 256;
  localparam int NUM_SWAP_SLOTS = 256;
  localparam int OWNER_BITS     = 16;
  localparam int FRAME_W        = 8;
  localparam int CHUNK_BITS     = 8;
  localparam int CHUNK_POS_W    = $clog2(CHUNK_BITS);
  localparam int CHUNKS         = NUM_FRAMES / CHUNK_BITS;
  localparam int CHUNK_W        = $clog2(CHUNKS);
  localparam int CNT_W          = CHUNK_W + 1;
  localparam int SWAP_CHUNKS    = NUM_SWAP_SLOTS / CHUNK_BITS;

  localparam logic [FRAME_W-1:0] RESERVED_RESET = FRAME_W'(30);

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE_FRAME = 2'd1,
    OP_FREE_SWAP  = 2'd2,
    OP_NONE       = 2'd3
  } pfa_op_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [FRAME_W-1:0]    slot_index;
    logic [OWNER_BITS-1:0] owner_tag;
  } pfa_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0]    frame;
    logic                  evicted;
    logic [OWNER_BITS-1:0] victim_owner;
    logic [FRAME_W-1:0]    swap_slot;
    logic                  status;
  } pfa_out_t;

endpackage

@@ rtl/pfa_scan.sv @@
// ----------------------------------------------------------------------------
// pfa_scan
// Shared chunk scanner: selects one chunk of a busy map and finds the
// lowest free bit among the enabled positions.
// ----------------------------------------------------------------------------
module pfa_scan (
  input  logic [pfa_pkg::NUM_FRAMES-1:0]  busy_map,
  input  logic [pfa_pkg::CHUNK_W-1:0]     chunk,
  input  logic [pfa_pkg::CHUNK_BITS-1:0]  keep,
  output logic                            hit,
  output logic [pfa_pkg::CHUNK_POS_W-1:0] pos
);
  import pfa_pkg::*;

  logic [CHUNK_BITS-1:0] bits;
  logic [CHUNK_BITS-1:0] free_bits;

  assign bits      = busy_map[{chunk, {CHUNK_POS_W{1'b0}}} +: CHUNK_BITS];
  assign free_bits = ~bits & keep;
  assign hit       = |free_bits;

  always_comb begin
    pos = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = CHUNK_POS_W'(i);
      end
    end
  end

endmodule

@@ rtl/pfa_owner_ram.sv @@
// ----------------------------------------------------------------------------
// pfa_owner_ram
// Owner tag store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfa_owner_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [pfa_pkg::FRAME_W-1:0]     waddr,
  input  logic [pfa_pkg::OWNER_BITS-1:0]  wdata,
  input  logic                            re,
  input  logic [pfa_pkg::FRAME_W-1:0]     raddr,
  output logic [pfa_pkg::OWNER_BITS-1:0]  rdata
);
  import pfa_pkg::*;

  logic [OWNER_BITS-1:0] mem [NUM_FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/page_frame_allocator_with_eviction_unit.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator_with_eviction_unit
// Next-fit frame allocator with round-robin eviction to swap slots.
// Free ops go straight to the response step; allocate scans for a free frame
// and, if none, for a swap slot to evict to (8 busy bits per scan cycle,
// one shared scanner, then an owner tag read and write-back).
// One item at a time, a new one only in idle; a new item is accepted while
// a result waits, and is held in the response step until the output is free.
// Synchronous active-low reset: all frames and swap slots free, victim 30.
// ----------------------------------------------------------------------------
module page_frame_allocator_with_eviction_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pfa_pkg::pfa_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pfa_pkg::pfa_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfa_pkg::FRAME_W-1:0]   cfg_data
);
  import pfa_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FSCAN = 6'b000010,
    ST_SSCAN = 6'b000100,
    ST_ORD   = 6'b001000,
    ST_OWB   = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [FRAME_W-1:0]      start_r, start_nxt;
  logic [FRAME_W-1:0]      vp_r, vp_nxt;
  logic [FRAME_W-1:0]      reserved_r, reserved_nxt;
  logic [NUM_FRAMES-1:0]   fbusy_r, fbusy_nxt;
  logic [NUM_SWAP_SLOTS-1:0] sbusy_r, sbusy_nxt;
  logic [OWNER_BITS-1:0]   tag_r, tag_nxt;
  pfa_out_t                res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pfa_out_t                out_data_r, out_data_nxt;

  logic [NUM_FRAMES-1:0]   scan_map;
  logic [CHUNK_W-1:0]      scan_chunk;
  logic [CHUNK_BITS-1:0]   scan_keep;
  logic                    scan_hit;
  logic [CHUNK_POS_W-1:0]  scan_pos;
  logic [FRAME_W-1:0]      hit_idx;
  logic [CHUNK_W-1:0]      fscan_chunk;
  logic [CHUNK_POS_W-1:0]  start_lo;
  logic [FRAME_W-1:0]      victim;
  logic [FRAME_W-1:0]      victim_next;

  logic                    ram_we;
  logic [FRAME_W-1:0]      ram_waddr;
  logic [OWNER_BITS-1:0]   ram_wdata;
  logic                    ram_re;
  logic [OWNER_BITS-1:0]   ram_rdata;

  pfa_scan u_scan (
    .busy_map (scan_map),
    .chunk    (scan_chunk),
    .keep     (scan_keep),
    .hit      (scan_hit),
    .pos      (scan_pos)
  );

  pfa_owner_ram u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (res_r.frame),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign fscan_chunk = start_r[FRAME_W-1:CHUNK_POS_W] + cnt_r[CHUNK_W-1:0];
  assign start_lo    = start_r[CHUNK_POS_W-1:0];
  assign hit_idx     = {scan_chunk, scan_pos};

  // victim never below the reserve; wraps back to it after the last frame
  assign victim      = (vp_r < reserved_r) ? reserved_r : vp_r;
  assign victim_next = (victim == FRAME_W'(NUM_FRAMES - 1)) ? reserved_r
                                                             : victim + 1'b1;

  always_comb begin
    scan_map   = fbusy_r;
    scan_chunk = fscan_chunk;
    scan_keep  = {CHUNK_BITS{1'b1}};
    if (state_r == ST_SSCAN) begin
      scan_map   = sbusy_r;
      scan_chunk = cnt_r[CHUNK_W-1:0];
    end else if (cnt_r == '0) begin
      scan_keep = {CHUNK_BITS{1'b1}} << start_lo;
    end else if (cnt_r == CNT_W'(CHUNKS)) begin
      scan_keep = ~({CHUNK_BITS{1'b1}} << start_lo);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    vp_nxt        = vp_r;
    reserved_nxt  = reserved_r;
    fbusy_nxt     = fbusy_r;
    sbusy_nxt     = sbusy_r;
    tag_nxt       = tag_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = res_r.frame;
    ram_wdata     = tag_r;
    ram_re        = 1'b0;

    if (cfg_valid) begin
      reserved_nxt = cfg_data;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tag_nxt = in_data.owner_tag;
          res_nxt = '0;
          cnt_nxt = '0;
          case (in_data.operation)
            OP_ALLOC: begin
              state_nxt = ST_FSCAN;
            end
            OP_FREE_FRAME: begin
              fbusy_nxt[in_data.slot_index] = 1'b0;
              state_nxt = ST_RESP;
            end
            OP_FREE_SWAP: begin
              sbusy_nxt[in_data.slot_index] = 1'b0;
              state_nxt = ST_RESP;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_FSCAN: begin
        if (scan_hit) begin
          fbusy_nxt[hit_idx] = 1'b1;
          ram_we             = 1'b1;
          ram_waddr          = hit_idx;
          start_nxt          = hit_idx + 1'b1;
          res_nxt.frame      = hit_idx;
          state_nxt          = ST_RESP;
        end else if (cnt_r == CNT_W'(CHUNKS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SSCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SSCAN: begin
        if (scan_hit) begin
          sbusy_nxt[hit_idx] = 1'b1;
          res_nxt.swap_slot  = hit_idx;
          res_nxt.evicted    = 1'b1;
          res_nxt.frame      = victim;
          vp_nxt             = victim_next;
          state_nxt          = ST_ORD;
        end else if (cnt_r == CNT_W'(SWAP_CHUNKS - 1)) begin
          res_nxt.status = 1'b1;
          state_nxt      = ST_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ORD: begin
        ram_re    = 1'b1;
        state_nxt = ST_OWB;
      end
      ST_OWB: begin
        res_nxt.victim_owner = ram_rdata;
        ram_we               = 1'b1;
        state_nxt            = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      start_r     <= '0;
      vp_r        <= RESERVED_RESET;
      reserved_r  <= RESERVED_RESET;
      fbusy_r     <= '0;
      sbusy_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      vp_r        <= vp_nxt;
      reserved_r  <= reserved_nxt;
      fbusy_r     <= fbusy_nxt;
      sbusy_r     <= sbusy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/pfa_chk.sv @@
// ----------------------------------------------------------------------------
// pfa_chk
// Port-level checks for the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_chk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  pfa_pkg::pfa_out_t out_data
);
  import pfa_pkg::*;

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |->
      (!out_data.evicted && out_data.frame == '0 && out_data.swap_slot == '0 &&
       out_data.victim_owner == '0))
    else $error("swap-full result carries data");

  a_no_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.evicted) |->
      (out_data.swap_slot == '0 && out_data.victim_owner == '0))
    else $error("eviction fields set without eviction");

endmodule

bind page_frame_allocator_with_eviction_unit pfa_chk u_pfa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
